// ===== hw/rtl/frocm_pkg.sv =====
// shared types, widths and codes of the fifo replacement object cache map
`default_nettype none

package frocm_pkg;

    // request and register field widths
    localparam int FUNC_W    = 2;
    localparam int NOBJ_W    = 13;
    localparam int SLOTS_W   = 7;
    localparam int OLEN_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int MAX_OBJECTS_DEF = 4096;
    localparam int NUM_SLOTS_DEF   = 64;

    // register reset values
    localparam logic [NOBJ_W-1:0]  NUM_OBJECTS_RST   = NOBJ_W'(4096);
    localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RST  = SLOTS_W'(64);
    localparam logic [OLEN_W-1:0]  OBJECT_LENGTH_RST = OLEN_W'(1024);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OBJECTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_LENGTH = 2'd2;

    // request operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PLACE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // capture request, read object map
        logic owner_rd;  // read slot owner map at the looked-up slot
        logic commit;    // update maps and load the result register
    } frocm_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frocm_ctrl.sv =====
// controller state machine of the fifo replacement object cache map
`default_nettype none

module frocm_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output frocm_pkg::frocm_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OWNER,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result register may be reloaded once empty or being taken
    assign out_free = !out_valid_reg || out_ready;

    // commands
    always_comb
    begin
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.owner_rd = (state_reg == ST_OWNER);
        cmd.commit   = (state_reg == ST_DECIDE) && out_free;
    end

    // next state and result valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_OWNER;
                end
            end
            ST_OWNER:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/frocm_dp.sv =====
// datapath of the fifo replacement object cache map: registers, maps, ring pointer
`default_nettype none

module frocm_dp
#(
    parameter int MAX_OBJECTS = frocm_pkg::MAX_OBJECTS_DEF,
    parameter int NUM_SLOTS   = frocm_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W       = $clog2(MAX_OBJECTS),
    parameter int SLOT_W      = $clog2(NUM_SLOTS),
    parameter int OFF_W       = SLOT_W + frocm_pkg::OLEN_W
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [frocm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [frocm_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire frocm_pkg::frocm_cmd_t           cmd,
    input  wire logic [frocm_pkg::FUNC_W-1:0]    func,
    input  wire logic [IDX_W-1:0]                object_index,
    output logic                                 valid_res,
    output logic                                 hit,
    output logic [SLOT_W-1:0]                    slot,
    output logic [OFF_W-1:0]                     base_offset
);

    localparam int LIM_W  = (IDX_W + 1 > frocm_pkg::NOBJ_W) ? IDX_W + 1 : frocm_pkg::NOBJ_W;
    localparam int RING_W = (SLOT_W + 1 > frocm_pkg::SLOTS_W) ? SLOT_W + 1
                                                               : frocm_pkg::SLOTS_W;
    localparam int PROD_W = SLOT_W + frocm_pkg::OLEN_W;

    // configuration registers
    logic [frocm_pkg::NOBJ_W-1:0]  num_objects_reg;
    logic [frocm_pkg::SLOTS_W-1:0] slots_in_use_reg;
    logic [frocm_pkg::OLEN_W-1:0]  object_length_reg;

    // request registers
    logic [frocm_pkg::FUNC_W-1:0]  func_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          in_range_reg;

    // maps; object map validity is proven by the owner map
    logic [SLOT_W-1:0]             obj_mem [MAX_OBJECTS];
    logic [IDX_W-1:0]              owner_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]          slot_valid_reg;
    logic [SLOT_W-1:0]             obj_rdata_reg;
    logic [IDX_W-1:0]              owner_rdata_reg;
    logic                          slot_ok_reg;
    logic [SLOT_W-1:0]             next_slot_reg;
    logic [SLOT_W-1:0]             next_slot_next;

    // result registers
    logic                          valid_res_reg;
    logic                          hit_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic [OFF_W-1:0]              base_offset_reg;

    logic [LIM_W-1:0]              obj_limit;
    logic [RING_W-1:0]             ring_size;
    logic [RING_W-1:0]             ns_plus;
    logic                          active;
    logic                          hit_w;
    logic                          alloc_w;
    logic [SLOT_W-1:0]             res_slot;
    logic [PROD_W-1:0]             prod;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_objects_reg   <= frocm_pkg::NUM_OBJECTS_RST;
            slots_in_use_reg  <= frocm_pkg::SLOTS_IN_USE_RST;
            object_length_reg <= frocm_pkg::OBJECT_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                frocm_pkg::CFG_NUM_OBJECTS:
                    num_objects_reg   <= frocm_pkg::NOBJ_W'(cfg_wdata);
                frocm_pkg::CFG_SLOTS_IN_USE:
                    slots_in_use_reg  <= frocm_pkg::SLOTS_W'(cfg_wdata);
                frocm_pkg::CFG_OBJECT_LENGTH:
                    object_length_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // object limit, clamped to the map depth
    always_comb
    begin
        if (LIM_W'(num_objects_reg) > LIM_W'(MAX_OBJECTS))
        begin
            obj_limit = LIM_W'(MAX_OBJECTS);
        end
        else
        begin
            obj_limit = LIM_W'(num_objects_reg);
        end
    end

    // ring size saturated into one to the slot count
    always_comb
    begin
        if (slots_in_use_reg == '0)
        begin
            ring_size = RING_W'(1);
        end
        else if (RING_W'(slots_in_use_reg) > RING_W'(NUM_SLOTS))
        begin
            ring_size = RING_W'(NUM_SLOTS);
        end
        else
        begin
            ring_size = RING_W'(slots_in_use_reg);
        end
    end

    // pointer advance with wrap
    assign ns_plus        = RING_W'(next_slot_reg) + RING_W'(1);
    assign next_slot_next = (ns_plus >= ring_size) ? '0 : SLOT_W'(ns_plus);

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg     <= func;
            idx_reg      <= object_index;
            in_range_reg <= (LIM_W'(object_index) < obj_limit);
        end
    end

    // hit and allocate decision
    always_comb
    begin
        active  = in_range_reg &&
                  ((func_reg == frocm_pkg::FUNC_LOOKUP) || (func_reg == frocm_pkg::FUNC_PLACE));
        hit_w   = 1'b0;
        alloc_w = 1'b0;
        if (active && slot_ok_reg && (owner_rdata_reg == idx_reg))
        begin
            hit_w = 1'b1;
        end
        else if (active && (func_reg == frocm_pkg::FUNC_PLACE))
        begin
            alloc_w = 1'b1;
        end
        if (hit_w)
        begin
            res_slot = obj_rdata_reg;
        end
        else if (alloc_w)
        begin
            res_slot = next_slot_reg;
        end
        else
        begin
            res_slot = '0;
        end
    end

    assign prod = PROD_W'(res_slot) * PROD_W'(object_length_reg);

    // object map: read at request index, written on allocation
    always_ff @(posedge clk)
    begin
        if (cmd.commit && alloc_w)
        begin
            obj_mem[idx_reg] <= next_slot_reg;
        end
        if (cmd.accept)
        begin
            obj_rdata_reg <= obj_mem[object_index];
        end
    end

    // owner map: read at looked-up slot, written on allocation
    always_ff @(posedge clk)
    begin
        if (cmd.commit && alloc_w)
        begin
            owner_mem[next_slot_reg] <= idx_reg;
        end
        if (cmd.owner_rd)
        begin
            owner_rdata_reg <= owner_mem[obj_rdata_reg];
            slot_ok_reg     <= (RING_W'(obj_rdata_reg) < RING_W'(NUM_SLOTS)) &&
                               slot_valid_reg[obj_rdata_reg];
        end
    end

    // slot valid bits and ring pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            next_slot_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            if (func_reg == frocm_pkg::FUNC_CLEAR)
            begin
                slot_valid_reg <= '0;
            end
            else if (alloc_w)
            begin
                slot_valid_reg[next_slot_reg] <= 1'b1;
                next_slot_reg                 <= next_slot_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            valid_res_reg   <= hit_w || alloc_w;
            hit_reg         <= hit_w;
            slot_reg        <= res_slot;
            base_offset_reg <= OFF_W'(prod);
        end
    end

    assign valid_res   = valid_res_reg;
    assign hit         = hit_reg;
    assign slot        = slot_reg;
    assign base_offset = base_offset_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_replacement_object_cache_map_unit.sv =====
// top level of the fifo replacement object cache map
`default_nettype none

// channel    direction  handshake            payload
// cfg        in         cfg_we               cfg_index, cfg_wdata
// request    in         in_valid / in_ready  func, object_index
// result     out        out_valid / out_ready valid_res, hit, slot, base_offset
//
// one request in flight; an accepted request reads the object map, then the
// owner map, and then loads the result register
// a new request is taken the cycle after the result is loaded, while it waits
// reset clears the slot valid bits and ring pointer at once; no clearing pass
// a stalled result holds the commit step until the result register frees up

module fifo_replacement_object_cache_map_unit
#(
    parameter int MAX_OBJECTS = frocm_pkg::MAX_OBJECTS_DEF,
    parameter int NUM_SLOTS   = frocm_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W       = $clog2(MAX_OBJECTS),
    parameter int SLOT_W      = $clog2(NUM_SLOTS),
    parameter int OFF_W       = SLOT_W + frocm_pkg::OLEN_W
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [frocm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [frocm_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [frocm_pkg::FUNC_W-1:0]    func,
    input  wire logic [IDX_W-1:0]                object_index,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 valid_res,
    output logic                                 hit,
    output logic [SLOT_W-1:0]                    slot,
    output logic [OFF_W-1:0]                     base_offset
);

    frocm_pkg::frocm_cmd_t cmd;

    // controller
    frocm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath
    frocm_dp
    #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .NUM_SLOTS   (NUM_SLOTS),
        .IDX_W       (IDX_W),
        .SLOT_W      (SLOT_W),
        .OFF_W       (OFF_W)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .func         (func),
        .object_index (object_index),
        .valid_res    (valid_res),
        .hit          (hit),
        .slot         (slot),
        .base_offset  (base_offset)
    );

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // a result without a slot carries zero slot and offset
    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> (slot == '0) && (base_offset == '0) && !hit)
        else $error("empty result carries slot data");

    // result stays loaded until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(base_offset))
        else $error("pending result changed");

endmodule

`default_nettype wire

// ===== dv/tb_fifo_replacement_object_cache_map_unit.sv =====
// testbench for the fifo replacement object cache map: directed and random requests
`timescale 1ns / 100ps

module tb_fifo_replacement_object_cache_map_unit;

    import frocm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_OBJECTS_DEF);
    localparam int SLOT_W = $clog2(NUM_SLOTS_DEF);
    localparam int OFF_W  = SLOT_W + OLEN_W;

    // func code 3 has no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic              valid_res;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  base_offset;
    } cache_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func;
    logic [IDX_W-1:0]     object_index;
    logic                 out_valid;
    logic                 out_ready;
    logic                 valid_res;
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic [OFF_W-1:0]     base_offset;

    // directory shadow kept by the predictor
    bit                cached_obj [0:MAX_OBJECTS_DEF-1];
    logic [SLOT_W-1:0] cached_slot [0:MAX_OBJECTS_DEF-1];
    bit                slot_taken [0:NUM_SLOTS_DEF-1];
    logic [IDX_W-1:0]  slot_owner [0:NUM_SLOTS_DEF-1];
    logic [SLOT_W-1:0] ring_ptr;

    // register shadow
    logic [NOBJ_W-1:0]  cur_num_objects;
    logic [SLOTS_W-1:0] cur_slots;
    logic [OLEN_W-1:0]  cur_obj_len;

    cache_result_t pending_results[$];
    int            mismatch_count;
    bit            tx_idle;
    bit            rx_idle;

    fifo_replacement_object_cache_map_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .object_index (object_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .hit          (hit),
        .slot         (slot),
        .base_offset  (base_offset)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // invalidate both maps, pointer untouched
    function automatic void clear_directory();
        for (int i = 0; i < MAX_OBJECTS_DEF; i++)
        begin
            cached_obj[i]  = 1'b0;
            cached_slot[i] = '0;
        end
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            slot_taken[i] = 1'b0;
            slot_owner[i] = '0;
        end
    endfunction

    // ring length after saturation into 1..NUM_SLOTS
    function automatic int unsigned ring_length();
        if (cur_slots == 0)
            return 1;
        else if (cur_slots > NUM_SLOTS_DEF)
            return NUM_SLOTS_DEF;
        return cur_slots;
    endfunction

    // directory update and result for one request
    function automatic cache_result_t directory_predict(input logic [FUNC_W-1:0] op,
                                                        input logic [IDX_W-1:0] idx);
        cache_result_t r;
        int unsigned   limit;
        int unsigned   s;
        r = '0;
        limit = (cur_num_objects > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : cur_num_objects;
        if (op == FUNC_CLEAR)
            clear_directory();
        else if (op != FUNC_UNUSED && idx < limit)
        begin
            if (cached_obj[idx])
            begin
                r.valid_res = 1'b1;
                r.hit       = 1'b1;
                r.slot      = cached_slot[idx];
            end
            else if (op == FUNC_PLACE)
            begin
                s = ring_ptr;
                // evict the current owner of the slot under the pointer
                if (slot_taken[s])
                    cached_obj[slot_owner[s]] = 1'b0;
                cached_obj[idx]  = 1'b1;
                cached_slot[idx] = SLOT_W'(s);
                slot_taken[s]    = 1'b1;
                slot_owner[s]    = idx;
                ring_ptr         = (s + 1 >= ring_length()) ? '0 : SLOT_W'(s + 1);
                r.valid_res      = 1'b1;
                r.slot           = SLOT_W'(s);
            end
            if (r.valid_res)
                r.base_offset = OFF_W'(int'(r.slot) * int'(cur_obj_len));
        end
        return r;
    endfunction

    // one field of a result against its expected value
    task automatic field_compare(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        cache_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual valid_res %0d hit %0d slot %0d offset %0d",
                         $time, valid_res, hit, slot, base_offset);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                field_compare("valid_res", want.valid_res, valid_res);
                field_compare("hit", want.hit, hit);
                field_compare("slot", want.slot, slot);
                field_compare("base_offset", want.base_offset, base_offset);
            end
        end
    end

    // result side: random stall before each result while rx_idle is set
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // send one request after a random gap while tx_idle is set, predict on acceptance
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= op;
        object_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(directory_predict(op, idx));
    endtask

    // stop sending and wait until every result is back
    task automatic drain_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_OBJECTS:   cur_num_objects = data[NOBJ_W-1:0];
            CFG_SLOTS_IN_USE:  cur_slots       = data[SLOTS_W-1:0];
            CFG_OBJECT_LENGTH: cur_obj_len     = data[OLEN_W-1:0];
            default: ;
        endcase
    endtask

    // every operation at reset settings, hits, misses and clear
    task automatic test_basic_ops();
        send_request(FUNC_LOOKUP, 12'd0);
        send_request(FUNC_PLACE, 12'd0);
        send_request(FUNC_PLACE, 12'd0);
        send_request(FUNC_LOOKUP, 12'd0);
        send_request(FUNC_PLACE, 12'd4095);
        send_request(FUNC_LOOKUP, 12'd4095);
        send_request(FUNC_UNUSED, 12'd4095);
        send_request(FUNC_CLEAR, 12'd0);
        send_request(FUNC_LOOKUP, 12'd4095);
        send_request(FUNC_PLACE, 12'hAAA);
        send_request(FUNC_PLACE, 12'h555);
    endtask

    // object limit of one, zero and above the maximum; offset extremes
    task automatic test_config_extremes();
        drain_requests();
        write_reg(CFG_NUM_OBJECTS, 16'd1);
        send_request(FUNC_PLACE, 12'd1);
        send_request(FUNC_PLACE, 12'd0);
        send_request(FUNC_LOOKUP, 12'd4095);
        drain_requests();
        write_reg(CFG_NUM_OBJECTS, 16'd0);
        send_request(FUNC_PLACE, 12'd0);
        drain_requests();
        write_reg(CFG_NUM_OBJECTS, 16'd8191);
        write_reg(CFG_SLOTS_IN_USE, 16'd127);
        write_reg(CFG_OBJECT_LENGTH, 16'd65535);
        send_request(FUNC_LOOKUP, 12'd0);
        send_request(FUNC_PLACE, 12'd100);
        drain_requests();
        write_reg(CFG_OBJECT_LENGTH, 16'd0);
        send_request(FUNC_PLACE, 12'd101);
    endtask

    // pointer beyond a shrunken ring, then a ring of one slot
    task automatic test_ring_pointer();
        drain_requests();
        write_reg(CFG_OBJECT_LENGTH, 16'd1024);
        write_reg(CFG_SLOTS_IN_USE, 16'd2);
        send_request(FUNC_PLACE, 12'd200);
        send_request(FUNC_PLACE, 12'd201);
        send_request(FUNC_PLACE, 12'd202);
        send_request(FUNC_PLACE, 12'd203);
        send_request(FUNC_LOOKUP, 12'd201);
        drain_requests();
        write_reg(CFG_SLOTS_IN_USE, 16'd0);
        send_request(FUNC_PLACE, 12'd204);
        send_request(FUNC_PLACE, 12'd205);
        send_request(FUNC_LOOKUP, 12'd204);
    endtask

    // one setting, then random requests mostly around a small working set
    task automatic run_phase(input logic [CFG_W-1:0] nobj, input logic [CFG_W-1:0] slots,
                             input logic [CFG_W-1:0] len, input bit tx, input bit rx,
                             input int count);
        int unsigned      limit;
        int unsigned      span;
        int unsigned      ws_base;
        int unsigned      pick;
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0]  idx;
        drain_requests();
        write_reg(CFG_NUM_OBJECTS, nobj);
        write_reg(CFG_SLOTS_IN_USE, slots);
        write_reg(CFG_OBJECT_LENGTH, len);
        tx_idle = tx;
        rx_idle = rx;
        limit   = (cur_num_objects > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : cur_num_objects;
        span    = ring_length() + ring_length() / 2 + 2;
        ws_base = 0;
        for (int k = 0; k < count; k++)
        begin
            // move the working set now and then
            if (k % 40 == 0)
                ws_base = (limit > 1) ? $urandom_range(0, limit - 1) : 0;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                op = FUNC_PLACE;
            else if (pick < 88)
                op = FUNC_LOOKUP;
            else if (pick < 94)
                op = FUNC_CLEAR;
            else
                op = FUNC_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                idx = IDX_W'(ws_base + $urandom_range(0, span - 1));
            else if (pick < 90)
                idx = IDX_W'($urandom_range(0, MAX_OBJECTS_DEF - 1));
            else if (limit >= MAX_OBJECTS_DEF)
                idx = IDX_W'(MAX_OBJECTS_DEF - 1 - $urandom_range(0, 1));
            else
                idx = IDX_W'(limit - 1 + $urandom_range(0, 2));
            send_request(op, idx);
        end
    endtask

    // fixed corner settings, then random settings
    task automatic test_random_traffic();
        logic [CFG_W-1:0] nobj;
        run_phase(16'd4096, 16'd64, 16'd65535, 1'b1, 1'b1, 250);
        run_phase(16'd300, 16'd16, CFG_W'($urandom), 1'b0, 1'b0, 250);
        run_phase(16'd8191, 16'd1, 16'd0, 1'b1, 1'b0, 250);
        run_phase(16'd1, 16'd127, CFG_W'($urandom), 1'b0, 1'b1, 100);
        for (int p = 0; p < 4; p++)
        begin
            if ($urandom_range(0, 7) == 0)
                nobj = CFG_W'($urandom_range(MAX_OBJECTS_DEF + 1, 8191));
            else
                nobj = CFG_W'($urandom_range(1, MAX_OBJECTS_DEF));
            run_phase(nobj, CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 65535)),
                      1'($urandom), 1'($urandom), 225);
        end
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_NUM_OBJECTS;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        func            = FUNC_LOOKUP;
        object_index    = '0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        mismatch_count  = 0;
        cur_num_objects = NUM_OBJECTS_RST;
        cur_slots       = SLOTS_IN_USE_RST;
        cur_obj_len     = OBJECT_LENGTH_RST;
        ring_ptr        = '0;
        clear_directory();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_config_extremes();
        test_ring_pointer();
        test_random_traffic();

        drain_requests();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
